@@ src/qphs_pkg.sv @@
// ============================================================================
// qphs_pkg
// Shared sizes, action codes, controller states and the command/status
// structs of the quadratic-probe hash set.
// ============================================================================
package qphs_pkg;

    localparam int TABLE_SLOTS = 11;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam int KEY_W       = 31;
    localparam int ACT_W       = 2;

    // home slot is built from key digits, most significant first
    localparam int DIG_W       = 4;
    localparam int DIGITS      = (KEY_W + DIG_W - 1) / DIG_W;
    localparam int KEY_PAD     = DIGITS * DIG_W;
    localparam int DCNT_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int REM_W       = SLOT_W + DIG_W;

    localparam int OUT_SLOT_W  = 4;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic key_load;
        logic mod_step;
        logic probe_start;
        logic probe_step;
        logic wr_en;
        logic clear_all;
        logic res_load;
        logic res_ok;
        logic res_use_pos;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_last;
        logic chk_live;
        logic chk_vld;
        logic chk_match;
        logic probe_end;
    } t_dp_status;

endpackage

@@ src/qphs_datapath.sv @@
// ============================================================================
// qphs_datapath
// Home-slot remainder unit, incremental quadratic probe generator, key store
// with registered read, valid bits and the result register.
// ============================================================================
module qphs_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qphs_pkg::t_dp_cmd                 i_cmd,
    input  logic [qphs_pkg::KEY_W-1:0]        i_key,
    output qphs_pkg::t_dp_status              o_status,
    output logic                              o_res_success,
    output logic [qphs_pkg::OUT_SLOT_W-1:0]   o_res_slot
);

    localparam logic [qphs_pkg::REM_W-1:0]    T_REM = qphs_pkg::REM_W'(qphs_pkg::TABLE_SLOTS);
    localparam logic [qphs_pkg::SLOT_W:0]     T_SUM = (qphs_pkg::SLOT_W+1)'(qphs_pkg::TABLE_SLOTS);

    logic [qphs_pkg::KEY_W-1:0]   r_key;
    logic [qphs_pkg::KEY_PAD-1:0] r_shift;
    logic [qphs_pkg::DCNT_W-1:0]  r_dig;
    logic [qphs_pkg::SLOT_W-1:0]  r_rem;
    logic [qphs_pkg::SLOT_W-1:0]  n_rem;

    logic [qphs_pkg::SLOT_W-1:0]  r_pos;
    logic [qphs_pkg::SLOT_W-1:0]  n_pos;
    logic [qphs_pkg::SLOT_W-1:0]  r_inc;
    logic [qphs_pkg::SLOT_W-1:0]  n_inc;
    logic [qphs_pkg::CNT_W-1:0]   r_cnt;

    logic                         r_chk_live;
    logic                         r_chk_vld;
    logic [qphs_pkg::SLOT_W-1:0]  r_chk_pos;
    logic [qphs_pkg::KEY_W-1:0]   r_rd_key;

    logic [qphs_pkg::TABLE_SLOTS-1:0] r_valid;
    logic [qphs_pkg::KEY_W-1:0]   r_keys [qphs_pkg::TABLE_SLOTS];

    logic                         r_res_ok;
    logic [qphs_pkg::SLOT_W-1:0]  r_res_slot;
    logic [qphs_pkg::SLOT_W+qphs_pkg::OUT_SLOT_W-1:0] slot_ext;

    logic                         probe_end;
    logic                         issue;

    // rem = (rem * 16 + digit) mod T, by four conditional subtracts of T*8..T
    always_comb begin
        logic [qphs_pkg::REM_W-1:0] v;
        v = {r_rem, r_shift[qphs_pkg::KEY_PAD-1 -: qphs_pkg::DIG_W]};
        for (int k = qphs_pkg::DIG_W - 1; k >= 0; k--) begin
            if (v >= (T_REM << k)) begin
                v = v - (T_REM << k);
            end
        end
        n_rem = v[qphs_pkg::SLOT_W-1:0];
    end

    // pos(i+1) = pos(i) + (2i+1) mod T
    always_comb begin
        logic [qphs_pkg::SLOT_W:0] psum;
        logic [qphs_pkg::SLOT_W:0] isum;
        psum = {1'b0, r_pos} + {1'b0, r_inc};
        isum = {1'b0, r_inc} + (qphs_pkg::SLOT_W+1)'(2);
        if (psum >= T_SUM) begin
            psum = psum - T_SUM;
        end
        if (isum >= T_SUM) begin
            isum = isum - T_SUM;
        end
        n_pos = psum[qphs_pkg::SLOT_W-1:0];
        n_inc = isum[qphs_pkg::SLOT_W-1:0];
    end

    assign probe_end = (r_cnt == qphs_pkg::CNT_W'(qphs_pkg::TABLE_SLOTS));
    assign issue     = i_cmd.probe_step && !probe_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_key   <= i_key;
            r_shift <= qphs_pkg::KEY_PAD'(i_key);
            r_rem   <= '0;
            r_dig   <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem   <= n_rem;
            r_shift <= r_shift << qphs_pkg::DIG_W;
            r_dig   <= r_dig + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_live <= 1'b0;
        end else if (i_cmd.probe_start) begin
            r_chk_live <= 1'b0;
        end else if (i_cmd.probe_step) begin
            r_chk_live <= !probe_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_start) begin
            r_pos <= n_rem;
            r_inc <= qphs_pkg::SLOT_W'(1);
            r_cnt <= '0;
        end else if (issue) begin
            r_chk_pos <= r_pos;
            r_chk_vld <= r_valid[r_pos];
            r_pos     <= n_pos;
            r_inc     <= n_inc;
            r_cnt     <= r_cnt + 1'b1;
        end
    end

    // key store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_keys[r_chk_pos] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_key <= r_keys[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_all) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[r_chk_pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_ok   <= i_cmd.res_ok;
            r_res_slot <= i_cmd.res_use_pos ? r_chk_pos : '0;
        end
    end

    assign slot_ext      = {qphs_pkg::OUT_SLOT_W'(0), r_res_slot};
    assign o_res_slot    = slot_ext[qphs_pkg::OUT_SLOT_W-1:0];
    assign o_res_success = r_res_ok;

    always_comb begin
        o_status.mod_last  = (r_dig == qphs_pkg::DCNT_W'(qphs_pkg::DIGITS - 1));
        o_status.chk_live  = r_chk_live;
        o_status.chk_vld   = r_chk_vld;
        o_status.chk_match = (r_rd_key == r_key);
        o_status.probe_end = probe_end;
    end

endmodule

@@ src/qphs_ctrl.sv @@
// ============================================================================
// qphs_ctrl
// Sequencer: takes one item, runs the home-slot digits and probe walk for
// insert/search, decides the outcome, hands the result to the output register.
// ============================================================================
module qphs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [qphs_pkg::ACT_W-1:0]    i_action,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  qphs_pkg::t_dp_status          i_status,
    output qphs_pkg::t_dp_cmd             o_cmd
);

    qphs_pkg::t_state             r_state;
    qphs_pkg::t_state             n_state;
    logic [qphs_pkg::ACT_W-1:0]   r_act;
    logic                         r_ok;
    logic                         n_ok;
    logic                         r_use_pos;
    logic                         n_use_pos;
    logic                         r_out_valid;

    logic accept;
    logic out_free;
    logic fin;
    logic fin_ok;

    assign o_s_tready = (r_state == qphs_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    // outcome of the probe in the compare slot
    always_comb begin
        fin    = 1'b0;
        fin_ok = 1'b0;
        if (i_status.chk_live) begin
            if (!i_status.chk_vld) begin
                fin    = 1'b1;
                fin_ok = (r_act == qphs_pkg::ACT_INSERT);
            end else if (r_act == qphs_pkg::ACT_SEARCH && i_status.chk_match) begin
                fin    = 1'b1;
                fin_ok = 1'b1;
            end else if (i_status.probe_end) begin
                fin    = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_ok      = r_ok;
        n_use_pos = r_use_pos;
        case (r_state)
            qphs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_ok      = (i_action == qphs_pkg::ACT_CLEAR);
                    n_use_pos = 1'b0;
                    case (i_action)
                        qphs_pkg::ACT_INSERT: n_state = qphs_pkg::ST_HOME;
                        qphs_pkg::ACT_SEARCH: n_state = qphs_pkg::ST_HOME;
                        default:              n_state = qphs_pkg::ST_DONE;
                    endcase
                end
            end
            qphs_pkg::ST_HOME: begin
                if (i_status.mod_last) begin
                    n_state = qphs_pkg::ST_PROBE;
                end
            end
            qphs_pkg::ST_PROBE: begin
                if (fin) begin
                    n_state   = qphs_pkg::ST_DONE;
                    n_ok      = fin_ok;
                    n_use_pos = fin_ok;
                end
            end
            qphs_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = qphs_pkg::ST_IDLE;
                end
            end
            default: n_state = qphs_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.res_ok      = r_ok;
        o_cmd.res_use_pos = r_use_pos;
        case (r_state)
            qphs_pkg::ST_IDLE: begin
                o_cmd.key_load  = accept;
                o_cmd.clear_all = accept && (i_action == qphs_pkg::ACT_CLEAR);
            end
            qphs_pkg::ST_HOME: begin
                o_cmd.mod_step    = 1'b1;
                o_cmd.probe_start = i_status.mod_last;
            end
            qphs_pkg::ST_PROBE: begin
                o_cmd.probe_step = !fin;
                o_cmd.wr_en      = fin && fin_ok && (r_act == qphs_pkg::ACT_INSERT);
            end
            qphs_pkg::ST_DONE: begin
                o_cmd.res_load = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qphs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_use_pos <= n_use_pos;
        if (accept) begin
            r_act <= i_action;
        end
    end

endmodule

@@ src/quadratic_probe_hash_set_core.sv @@
// ============================================================================
// quadratic_probe_hash_set_core
// Open-addressing hash set with quadratic probing over a small key table.
// ============================================================================
// Usage:
//   Input beats on the s channel: tuser carries the action (insert, search,
//   clear), tdata the key. Each beat yields exactly one result beat on the m
//   channel: tuser is the success flag, tdata the slot written or found.
//   Items are handled one at a time; o_s_tready is high only while the
//   sequencer is idle, and it is idle again while a result still sits in the
//   output register waiting for i_m_tready.
//   Insert/search: the key is reduced to its home slot digit by digit (4 key
//   bits a cycle), then one probe per cycle goes through the key store's
//   single read port, with a final compare on the registered read.
//   Clear empties every valid bit as it is accepted; it and the unused action
//   code go straight to the done state and then to the output register.
//   Reset empties the table and drops any pending result. A stalled receiver
//   holds the result; the next item is accepted but its result waits.
// ============================================================================
module quadratic_probe_hash_set_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [qphs_pkg::S_TDATA_W-1:0]    i_s_tdata,  // [30:0] key, [31] zero
    input  logic [qphs_pkg::ACT_W-1:0]        i_s_tuser,  // [1:0] action
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [qphs_pkg::M_TDATA_W-1:0]    o_m_tdata,  // [3:0] slot, [7:4] zero
    output logic [0:0]                        o_m_tuser   // [0] success
);

    qphs_pkg::t_dp_cmd                    cmd;
    qphs_pkg::t_dp_status                 status;
    logic                                 res_success;
    logic [qphs_pkg::OUT_SLOT_W-1:0]      res_slot;

    qphs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_action   (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qphs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key         (i_s_tdata[qphs_pkg::KEY_W-1:0]),
        .o_status      (status),
        .o_res_success (res_success),
        .o_res_slot    (res_slot)
    );

    assign o_m_tdata = qphs_pkg::M_TDATA_W'(res_slot);
    assign o_m_tuser = res_success;

endmodule

@@ src/qphs_checker.sv @@
// ============================================================================
// qphs_checker
// Port-level checks of the hash set core, bound to the top level.
// ============================================================================
module qphs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [qphs_pkg::M_TDATA_W-1:0]    o_m_tdata,
    input  logic [0:0]                        o_m_tuser
);

    // a held result beat must not drop
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // one item at a time: an accepted beat closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in progress");

    // a failed result never names a slot
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("slot nonzero on failed result");

    // reported slot lies inside the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (qphs_pkg::TABLE_SLOTS > 16) ||
                       (32'(o_m_tdata) < 32'(qphs_pkg::TABLE_SLOTS)))
        else $error("slot out of table range");

endmodule

bind quadratic_probe_hash_set_core qphs_checker u_qphs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

@@ bench/testbench.sv @@
// ============================================================================
// testbench
// Self-checking bench for quadratic_probe_hash_set_core. A behavioral copy of
// the slot table predicts every result. Directed items cover the key extremes,
// probe chains, a full probe sequence and the unused action. Random traffic
// follows, with random gaps on the input stream and stalls on the result stream.
// ============================================================================
module testbench;

    localparam logic [qphs_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [qphs_pkg::KEY_W-1:0] KEY_MAX    = '1;

    typedef struct packed {
        logic                            ok;
        logic [qphs_pkg::OUT_SLOT_W-1:0] slot;
    } t_outcome;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic [qphs_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic [qphs_pkg::ACT_W-1:0]     i_s_tuser  = '0;
    logic                           i_m_tready = 1'b0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [qphs_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]                     o_m_tuser;

    // shadow copy of the slot table
    logic [qphs_pkg::KEY_W-1:0] shadow_key  [qphs_pkg::TABLE_SLOTS];
    logic                       shadow_used [qphs_pkg::TABLE_SLOTS];

    t_outcome                   awaited_results[$];
    logic [qphs_pkg::KEY_W-1:0] inserted_keys[$];
    int                         fail_count = 0;
    int                         stall_left = 0;
    bit                         no_idle    = 1'b0;

    quadratic_probe_hash_set_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [30:0] key, [31] zero
        .i_s_tuser  (i_s_tuser),   // [1:0] action
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [3:0] slot, [7:4] zero
        .o_m_tuser  (o_m_tuser)    // [0] success
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one item to the shadow table and returns the outcome.
    function automatic t_outcome probe_table(logic [qphs_pkg::ACT_W-1:0] act,
                                             logic [qphs_pkg::KEY_W-1:0] key);
        t_outcome res;
        int       home;
        int       pos;
        int       i;
        res  = '0;
        home = int'(key % qphs_pkg::TABLE_SLOTS);
        case (act)
            qphs_pkg::ACT_INSERT: begin
                for (i = 0; i < qphs_pkg::TABLE_SLOTS; i++) begin
                    pos = (home + i * i) % qphs_pkg::TABLE_SLOTS;
                    if (!shadow_used[pos]) begin
                        shadow_key[pos]  = key;
                        shadow_used[pos] = 1'b1;
                        res.ok   = 1'b1;
                        res.slot = pos[qphs_pkg::OUT_SLOT_W-1:0];
                        break;
                    end
                end
            end
            qphs_pkg::ACT_SEARCH: begin
                for (i = 0; i < qphs_pkg::TABLE_SLOTS; i++) begin
                    pos = (home + i * i) % qphs_pkg::TABLE_SLOTS;
                    if (!shadow_used[pos])
                        break;
                    if (shadow_key[pos] == key) begin
                        res.ok   = 1'b1;
                        res.slot = pos[qphs_pkg::OUT_SLOT_W-1:0];
                        break;
                    end
                end
            end
            qphs_pkg::ACT_CLEAR: begin
                foreach (shadow_used[i])
                    shadow_used[i] = 1'b0;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [qphs_pkg::KEY_W-1:0] pick_key(bit from_inserted);
        int          r;
        logic [31:0] w;
        r = $urandom_range(99);
        w = $urandom;
        if (from_inserted && inserted_keys.size() > 0 && r < 50)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        if (r < 70)
            return qphs_pkg::KEY_W'($urandom_range(63));
        // keys sharing a few home slots build long probe chains
        if (r < 82)
            return qphs_pkg::KEY_W'(11 * $urandom_range(40) + $urandom_range(2));
        if (r < 88)
            return KEY_MAX - qphs_pkg::KEY_W'($urandom_range(30));
        return w[qphs_pkg::KEY_W-1:0];
    endfunction

    // sink side: random back-pressure on the result stream
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_m_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(99) < 12)
                stall_left = ($urandom_range(99) < 85) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 40);
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with none awaited: success %0d slot %0d",
                       o_m_tuser[0], o_m_tdata[qphs_pkg::OUT_SLOT_W-1:0]);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_m_tuser[0] !== want.ok) begin
                    $error("success: expected %0d, got %0d", want.ok, o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tdata[qphs_pkg::OUT_SLOT_W-1:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot,
                           o_m_tdata[qphs_pkg::OUT_SLOT_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(logic [qphs_pkg::ACT_W-1:0] act,
                             logic [qphs_pkg::KEY_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(qphs_pkg::S_TDATA_W - qphs_pkg::KEY_W){1'b0}}, key};
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        awaited_results.push_back(probe_table(act, key));
        if (act == qphs_pkg::ACT_INSERT) begin
            inserted_keys.push_back(key);
            if (inserted_keys.size() > 32)
                void'(inserted_keys.pop_front());
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(qphs_pkg::ACT_SEARCH, '0);
        send_item(qphs_pkg::ACT_SEARCH, KEY_MAX);
        send_item(ACT_UNUSED, KEY_MAX);
    endtask

    task automatic test_key_extremes();
        send_item(qphs_pkg::ACT_INSERT, '0);
        send_item(qphs_pkg::ACT_INSERT, KEY_MAX);
        send_item(qphs_pkg::ACT_SEARCH, KEY_MAX);
        send_item(qphs_pkg::ACT_SEARCH, '0);
        send_item(qphs_pkg::ACT_SEARCH, 31'd1);
    endtask

    // keys 0, 11, .. 55 share home slot 0 and fill every slot its probes reach
    task automatic test_probe_chain();
        int k;
        send_item(qphs_pkg::ACT_CLEAR, '0);
        for (k = 0; k < 6; k++)
            send_item(qphs_pkg::ACT_INSERT, 31'(11 * k));
        send_item(qphs_pkg::ACT_INSERT, 31'd66);   // free slots left but none reachable
        send_item(qphs_pkg::ACT_SEARCH, 31'd55);
        send_item(qphs_pkg::ACT_SEARCH, 31'd77);   // walks the whole sequence, no match
        send_item(qphs_pkg::ACT_INSERT, 31'd5);
        send_item(qphs_pkg::ACT_INSERT, 31'd5);    // duplicate goes further down the chain
        send_item(qphs_pkg::ACT_SEARCH, 31'd5);
        send_item(ACT_UNUSED, 31'd5);
        send_item(qphs_pkg::ACT_CLEAR, KEY_MAX);
        send_item(qphs_pkg::ACT_SEARCH, '0);
    endtask

    task automatic test_random_traffic(int n_items);
        int count;
        int burst;
        int r;
        count = 0;
        while (count < n_items) begin
            burst   = $urandom_range(20, 60);
            no_idle = ($urandom_range(99) < 20);
            repeat (burst) begin
                r = $urandom_range(99);
                if (r < 40)
                    send_item(qphs_pkg::ACT_INSERT, pick_key(1'b0));
                else if (r < 91)
                    send_item(qphs_pkg::ACT_SEARCH, pick_key(1'b1));
                else if (r < 97)
                    send_item(qphs_pkg::ACT_CLEAR, pick_key(1'b0));
                else
                    send_item(ACT_UNUSED, pick_key(1'b1));
                count++;
            end
            no_idle = 1'b0;
            if ($urandom_range(99) < 15)
                wait_drained();
        end
    endtask

    initial begin
        int waited;
        foreach (shadow_used[i]) begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_key_extremes();
        wait_drained();
        test_probe_chain();
        wait_drained();
        test_random_traffic(1550);
        go_idle();

        waited = 0;
        while (awaited_results.size() != 0 && waited < 50000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ quadratic_probe_hash_set_core.f @@
src/qphs_pkg.sv
src/qphs_datapath.sv
src/qphs_ctrl.sv
src/quadratic_probe_hash_set_core.sv
src/qphs_checker.sv
bench/testbench.sv
